// ===== design/cpg_pkg.sv =====
// shared constants, register codes and the arctangent table of the circle point generator
`default_nettype none
package cpg_pkg;

    // default design parameters
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int DEF_PHASE_BITS    = 32;

    // fixed field widths
    localparam int IDX_W    = 16;
    localparam int RAD_W    = 16;
    localparam int TURN_W   = 32;
    localparam int OUT_W    = 17;
    localparam int VEC_W    = 36;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // converged cordic gain reciprocal in Q30 and its width
    localparam int KINV_W = 30;
    localparam logic [KINV_W-1:0] KINV_Q30 = 30'd652032874;

    // output bound
    localparam int OUT_MAX = 65535;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_PHASE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 8'd3;

    // quadrant codes
    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    // atan(2^-k) as a fraction of a turn over 2^32
    localparam logic [31:0] ATAN_TURN32 [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // table entry aligned to the angle width, rounded half up when narrowed
    function automatic logic [63:0] atan_aligned(int k, int pb);
        logic [63:0] v;
        v = {32'd0, ATAN_TURN32[k]};
        if (pb >= 32) begin
            return v << (pb - 32);
        end
        return (v + (64'd1 << (32 - pb - 1))) >> (32 - pb);
    endfunction

endpackage
`default_nettype wire

// ===== design/cpg_prep.sv =====
// phase computation, quadrant split and start vector scaling, two register stages
`default_nettype none
module cpg_prep
    import cpg_pkg::*;
#(
    parameter int PHASE_BITS = DEF_PHASE_BITS,
    parameter int ZW         = DEF_PHASE_BITS + 1
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  [RAD_W-1:0]            i_radius,
    input  wire  [TURN_W-1:0]           i_phase_step,
    input  wire  [TURN_W-1:0]           i_start_phase,
    input  wire  [IDX_W-1:0]            i_sample_count,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire  [IDX_W-1:0]            i_sample_index,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic signed [VEC_W-1:0]     o_x,
    output logic signed [VEC_W-1:0]     o_y,
    output logic signed [ZW-1:0]        o_z,
    output logic [1:0]                  o_quad,
    output logic                        o_last
);

    localparam int GAIN_W = RAD_W + KINV_W;
    localparam int WIDE_W = TURN_W + PHASE_BITS;

    logic                  r_a_valid;
    logic [TURN_W-1:0]     r_a_prod;
    logic [GAIN_W-1:0]     r_a_gain;
    logic                  r_a_last;
    logic                  c_a_ready;

    logic                  r_b_valid;
    logic                  c_b_ready;

    logic [TURN_W-1:0]     c_phase;
    logic [WIDE_W-1:0]     c_wide;
    logic [PHASE_BITS-1:0] c_angle;
    logic [GAIN_W-1:0]     c_gain_rnd;
    logic [IDX_W+TURN_W-1:0] c_prod;

    assign c_b_ready = !r_b_valid || i_ready;
    assign c_a_ready = !r_a_valid || c_b_ready;
    assign o_ready   = c_a_ready;
    assign o_valid   = r_b_valid;

    // stage a: index times step, radius times gain reciprocal
    assign c_prod = i_sample_index * i_phase_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (c_a_ready) begin
            r_a_valid <= i_valid;
        end
        if (c_a_ready && i_valid) begin
            r_a_prod <= c_prod[TURN_W-1:0];
            r_a_gain <= i_radius * KINV_Q30;
            r_a_last <= (i_sample_index == i_sample_count);
        end
    end

    // stage b: wrap phase, align to the angle width, split off the quadrant, round the gain
    assign c_phase    = i_start_phase + r_a_prod;
    assign c_wide     = {c_phase, {PHASE_BITS{1'b0}}};
    assign c_angle    = c_wide[WIDE_W-1 -: PHASE_BITS];
    assign c_gain_rnd = r_a_gain + GAIN_W'(8192);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (c_b_ready) begin
            r_b_valid <= r_a_valid;
        end
        if (c_b_ready && r_a_valid) begin
            o_quad <= c_angle[PHASE_BITS-1 -: 2];
            o_z    <= ZW'({1'b0, c_angle[PHASE_BITS-3:0]});
            o_x    <= VEC_W'(c_gain_rnd[GAIN_W-1:14]);
            o_y    <= '0;
            o_last <= r_a_last;
        end
    end

endmodule
`default_nettype wire

// ===== design/cpg_cordic_stage.sv =====
// one registered cordic rotation step with a fixed shift
`default_nettype none
module cpg_cordic_stage
    import cpg_pkg::*;
#(
    parameter int PHASE_BITS = DEF_PHASE_BITS,
    parameter int ZW         = DEF_PHASE_BITS + 1,
    parameter int K          = 0
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire  signed [VEC_W-1:0]  i_x,
    input  wire  signed [VEC_W-1:0]  i_y,
    input  wire  signed [ZW-1:0]     i_z,
    input  wire  [1:0]               i_quad,
    input  wire                      i_last,
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic signed [VEC_W-1:0]  o_x,
    output logic signed [VEC_W-1:0]  o_y,
    output logic signed [ZW-1:0]     o_z,
    output logic [1:0]               o_quad,
    output logic                     o_last
);

    localparam int SH = K % 32;
    localparam logic signed [ZW-1:0] ATAN_T = ZW'(atan_aligned(SH, PHASE_BITS));

    logic                    r_valid;
    logic                    c_ready;
    logic signed [VEC_W-1:0] c_dx;
    logic signed [VEC_W-1:0] c_dy;
    logic signed [VEC_W-1:0] n_x;
    logic signed [VEC_W-1:0] n_y;
    logic signed [ZW-1:0]    n_z;

    assign c_ready = !r_valid || i_ready;
    assign o_ready = c_ready;
    assign o_valid = r_valid;

    // shifted cross terms, floor rounding
    assign c_dx = i_y >>> SH;
    assign c_dy = i_x >>> SH;

    // rotate toward zero residual angle
    always_comb begin
        if (i_z >= 0) begin
            n_x = i_x - c_dx;
            n_y = i_y + c_dy;
            n_z = i_z - ATAN_T;
        end else begin
            n_x = i_x + c_dx;
            n_y = i_y - c_dy;
            n_z = i_z + ATAN_T;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (c_ready) begin
            r_valid <= i_valid;
        end
        if (c_ready && i_valid) begin
            o_x    <= n_x;
            o_y    <= n_y;
            o_z    <= n_z;
            o_quad <= i_quad;
            o_last <= i_last;
        end
    end

endmodule
`default_nettype wire

// ===== design/cpg_post.sv =====
// quadrant fold, rounding and saturation into the output register
`default_nettype none
module cpg_post
    import cpg_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire  signed [VEC_W-1:0]  i_x,
    input  wire  signed [VEC_W-1:0]  i_y,
    input  wire  [1:0]               i_quad,
    input  wire                      i_last,
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic signed [OUT_W-1:0]  o_x_pos,
    output logic signed [OUT_W-1:0]  o_y_pos,
    output logic                     o_last
);

    localparam int FW = VEC_W + 1;
    localparam int RW = FW - 16;
    localparam logic signed [RW-1:0] HI = RW'(OUT_MAX);
    localparam logic signed [RW-1:0] LO = -RW'(OUT_MAX);

    logic                  r_valid;
    logic                  c_ready;
    logic signed [FW-1:0]  c_xe;
    logic signed [FW-1:0]  c_ye;
    logic signed [FW-1:0]  c_xf;
    logic signed [FW-1:0]  c_yf;
    logic signed [FW-1:0]  c_xs;
    logic signed [FW-1:0]  c_ys;
    logic signed [RW-1:0]  c_xr;
    logic signed [RW-1:0]  c_yr;
    logic signed [OUT_W-1:0] n_x_pos;
    logic signed [OUT_W-1:0] n_y_pos;

    assign c_ready = !r_valid || i_ready;
    assign o_ready = c_ready;
    assign o_valid = r_valid;

    assign c_xe = FW'(i_x);
    assign c_ye = FW'(i_y);

    // exact quarter-turn rotation
    always_comb begin
        case (i_quad)
            QUAD_FIRST: begin
                c_xf = c_xe;
                c_yf = c_ye;
            end
            QUAD_SECOND: begin
                c_xf = -c_ye;
                c_yf = c_xe;
            end
            QUAD_THIRD: begin
                c_xf = -c_xe;
                c_yf = -c_ye;
            end
            default: begin
                c_xf = c_ye;
                c_yf = -c_xe;
            end
        endcase
    end

    // round half up out of Q16
    assign c_xs = c_xf + FW'(32768);
    assign c_ys = c_yf + FW'(32768);
    assign c_xr = c_xs[FW-1:16];
    assign c_yr = c_ys[FW-1:16];

    // clamp to the output range
    always_comb begin
        if (c_xr > HI) begin
            n_x_pos = OUT_W'(HI);
        end else if (c_xr < LO) begin
            n_x_pos = OUT_W'(LO);
        end else begin
            n_x_pos = c_xr[OUT_W-1:0];
        end
        if (c_yr > HI) begin
            n_y_pos = OUT_W'(HI);
        end else if (c_yr < LO) begin
            n_y_pos = OUT_W'(LO);
        end else begin
            n_y_pos = c_yr[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (c_ready) begin
            r_valid <= i_valid;
        end
        if (c_ready && i_valid) begin
            o_x_pos <= n_x_pos;
            o_y_pos <= n_y_pos;
            o_last  <= i_last;
        end
    end

endmodule
`default_nettype wire

// ===== design/circle_point_generator.sv =====
// top level of the circle point generator: registers, phase front end, cordic pipe, output
//
//  channel  | direction | handshake                | data
//  ---------+-----------+--------------------------+------------------------------------
//  cfg      | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//  sample   | in        | i_in_valid / o_in_ready   | i_sample_index
//  point    | out       | o_out_valid / i_out_ready | o_x_pos, o_y_pos, o_last
//
// one word per cycle sustained while the output is not stalled; the pipe is two front end
// stages (multipliers, then phase add and gain rounding), one per rotation stage and
// the output register after the quadrant fold.
// every stage holds its own valid bit, so bubbles fill up while the output is stalled.
// synchronous active-low reset clears all valid bits and the configuration registers to zero.
// the cfg channel is always ready; writes to an index past the list are dropped.
`default_nettype none
module circle_point_generator
    import cpg_pkg::*;
#(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
    parameter int PHASE_BITS    = DEF_PHASE_BITS
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire  [IDX_W-1:0]         i_sample_index,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output logic signed [OUT_W-1:0]  o_x_pos,
    output logic signed [OUT_W-1:0]  o_y_pos,
    output logic                     o_last
);

    localparam int ZW = PHASE_BITS + 1;

    logic [RAD_W-1:0]  r_radius;
    logic [TURN_W-1:0] r_phase_step;
    logic [TURN_W-1:0] r_start_phase;
    logic [IDX_W-1:0]  r_sample_count;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius       <= '0;
            r_phase_step   <= '0;
            r_start_phase  <= '0;
            r_sample_count <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RADIUS:       r_radius       <= i_cfg_data[RAD_W-1:0];
                REG_PHASE_STEP:   r_phase_step   <= i_cfg_data[TURN_W-1:0];
                REG_START_PHASE:  r_start_phase  <= i_cfg_data[TURN_W-1:0];
                REG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[IDX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline links between stages
    logic                    s_valid [CORDIC_STAGES+1];
    logic                    s_ready [CORDIC_STAGES+1];
    logic signed [VEC_W-1:0] s_x     [CORDIC_STAGES+1];
    logic signed [VEC_W-1:0] s_y     [CORDIC_STAGES+1];
    logic signed [ZW-1:0]    s_z     [CORDIC_STAGES+1];
    logic [1:0]              s_quad  [CORDIC_STAGES+1];
    logic                    s_last  [CORDIC_STAGES+1];

    // phase front end
    cpg_prep #(
        .PHASE_BITS (PHASE_BITS),
        .ZW         (ZW)
    ) u_prep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_radius       (r_radius),
        .i_phase_step   (r_phase_step),
        .i_start_phase  (r_start_phase),
        .i_sample_count (r_sample_count),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_sample_index (i_sample_index),
        .o_valid        (s_valid[0]),
        .i_ready        (s_ready[0]),
        .o_x            (s_x[0]),
        .o_y            (s_y[0]),
        .o_z            (s_z[0]),
        .o_quad         (s_quad[0]),
        .o_last         (s_last[0])
    );

    // rotation stages
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        cpg_cordic_stage #(
            .PHASE_BITS (PHASE_BITS),
            .ZW         (ZW),
            .K          (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .o_ready (s_ready[k]),
            .i_x     (s_x[k]),
            .i_y     (s_y[k]),
            .i_z     (s_z[k]),
            .i_quad  (s_quad[k]),
            .i_last  (s_last[k]),
            .o_valid (s_valid[k+1]),
            .i_ready (s_ready[k+1]),
            .o_x     (s_x[k+1]),
            .o_y     (s_y[k+1]),
            .o_z     (s_z[k+1]),
            .o_quad  (s_quad[k+1]),
            .o_last  (s_last[k+1])
        );
    end

    // fold, round and output register; the final residual angle is not needed
    cpg_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid[CORDIC_STAGES]),
        .o_ready (s_ready[CORDIC_STAGES]),
        .i_x     (s_x[CORDIC_STAGES]),
        .i_y     (s_y[CORDIC_STAGES]),
        .i_quad  (s_quad[CORDIC_STAGES]),
        .i_last  (s_last[CORDIC_STAGES]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_x_pos (o_x_pos),
        .o_y_pos (o_y_pos),
        .o_last  (o_last)
    );

endmodule
`default_nettype wire

// ===== design/cpg_checker.sv =====
// port-level checks of the circle point generator and their bind
`default_nettype none
module cpg_checker
    import cpg_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      o_in_ready,
    input  wire                      o_out_valid,
    input  wire                      i_out_ready,
    input  wire  signed [OUT_W-1:0]  o_x_pos,
    input  wire  signed [OUT_W-1:0]  o_y_pos,
    input  wire                      o_last
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_x_pos) && $stable(o_y_pos) && $stable(o_last))
        else $error("stalled output word changed");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // a free output end lets the pipe take a word
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_ready || !o_out_valid) |-> o_in_ready)
        else $error("input blocked with free output");

    // saturation never yields the most negative code
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_x_pos != -17'sd65536) && (o_y_pos != -17'sd65536))
        else $error("output beyond saturation bound");

endmodule

bind circle_point_generator cpg_checker u_cpg_checker (.*);
`default_nettype wire

// ===== sim/tb.sv =====
// testbench of the circle point generator: directed table, random phases, cordic predictor
`timescale 1ns / 100ps
module tb;
    import cpg_pkg::*;

    localparam int NSTG      = DEF_CORDIC_STAGES;
    localparam int PB        = DEF_PHASE_BITS;
    localparam int LATENCY   = NSTG + 3;
    localparam int LONG_HOLD = 200;
    localparam int LIMIT     = 200000;
    localparam int NPHASE    = 6;
    localparam int PHASE_LEN = 125;
    localparam int NDIR      = 21;

    // write indexes past the register list, dropped by the block
    localparam logic [CFG_IDX_W-1:0] REG_PAST_END = REG_SAMPLE_COUNT + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ALL_ONES = '1;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic                    last;
    } point_t;

    // one directed word: raw register data, index and an optional literal point
    typedef struct packed {
        logic [31:0]             radius;
        logic [31:0]             step;
        logic [31:0]             start;
        logic [31:0]             count;
        logic [IDX_W-1:0]        idx;
        logic                    lit;
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic                    last;
    } drow_t;

    localparam drow_t DIRECTED [NDIR] = '{
        // reset values: zero radius, count zero
        '{32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 1'b1, 17'sd0, 17'sd0, 1'b1},
        '{32'd0, 32'd0, 32'd0, 32'd0, 16'hFFFF, 1'b1, 17'sd0, 17'sd0, 1'b0},
        // excess high bits of radius and count are dropped
        '{32'hFFFF_0000, 32'd0, 32'd0, 32'h0001_0005, 16'd5, 1'b1, 17'sd0, 17'sd0, 1'b1},
        // full radius on each quadrant boundary and near the ends of the turn, then eighth turns at several radii
        '{32'd65535, 32'd0, 32'h0000_0000, 32'd65535, 16'd0, 1'b0, 17'sd0, 17'sd0, 1'b0},
        '{32'd65535, 32'd0, 32'h4000_0000, 32'd65535, 16'hFFFF, 1'b0, 17'sd0, 17'sd0, 1'b0},
        '{32'd65535, 32'd0, 32'h8000_0000, 32'd65535, 16'd1, 1'b0, 17'sd0, 17'sd0, 1'b0},
        '{32'd65535, 32'd0, 32'hC000_0000, 32'd65535, 16'd2, 1'b0, 17'sd0, 17'sd0, 1'b0},
        '{32'd65535, 32'd0, 32'hFFFF_FFFF, 32'd65535, 16'd3, 1'b0, 17'sd0, 17'sd0, 1'b0},
        '{32'd65535, 32'd0, 32'h3FFF_FFFF, 32'd65535, 16'd4, 1'b0, 17'sd0, 17'sd0, 1'b0},
        '{32'd65535, 32'd0, 32'h2000_0000, 32'd65535, 16'd5, 1'b0, 17'sd0, 17'sd0, 1'b0},
        '{32'd1, 32'd0, 32'h2000_0000, 32'd65535, 16'd6, 1'b0, 17'sd0, 17'sd0, 1'b0},
        '{32'hFFFF_8000, 32'd0, 32'h6000_0000, 32'd65535, 16'd7, 1'b0, 17'sd0, 17'sd0, 1'b0},
        // phase wraparound
        '{32'd65535, 32'hFFFF_FFFF, 32'h1234_5678, 32'd0, 16'hFFFF, 1'b0,
          17'sd0, 17'sd0, 1'b0},
        '{32'd65535, 32'hFFFF_FFFF, 32'h1234_5678, 32'd0, 16'd0, 1'b0, 17'sd0, 17'sd0, 1'b0},
        '{32'd65535, 32'h8000_0000, 32'd0, 32'd3, 16'd1, 1'b0, 17'sd0, 17'sd0, 1'b0},
        '{32'd65535, 32'h8000_0000, 32'd0, 32'd3, 16'd3, 1'b0, 17'sd0, 17'sd0, 1'b0},
        '{32'd65535, 32'h0000_0001, 32'hFFFF_0000, 32'd0, 16'hFFFF, 1'b0,
          17'sd0, 17'sd0, 1'b0},
        '{32'd65535, 32'h0001_0000, 32'd0, 32'd0, 16'hFFFF, 1'b0, 17'sd0, 17'sd0, 1'b0},
        // alternating bit patterns, then one mixed setting
        '{32'd65535, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555, 16'h5555, 1'b0,
          17'sd0, 17'sd0, 1'b0},
        '{32'd65535, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555, 16'hAAAA, 1'b0,
          17'sd0, 17'sd0, 1'b0},
        '{32'd12345, 32'h0123_4567, 32'h89AB_CDEF, 32'd100, 16'd100, 1'b0,
          17'sd0, 17'sd0, 1'b0}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [IDX_W-1:0]        i_sample_index = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [OUT_W-1:0] o_x_pos;
    logic signed [OUT_W-1:0] o_y_pos;
    logic                    o_last;

    // register copies used by the predictor
    logic [RAD_W-1:0]  cfg_radius = '0;
    logic [TURN_W-1:0] cfg_step = '0;
    logic [TURN_W-1:0] cfg_start = '0;
    logic [IDX_W-1:0]  cfg_count = '0;

    point_t      pending_points [$];
    int unsigned bad_words = 0;
    int unsigned cycles = 0;
    int unsigned stall_left = 0;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    bit          src_idle_en = 1'b1;
    bit          sink_idle_en = 1'b1;

    circle_point_generator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_index (i_sample_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_x_pos        (o_x_pos),
        .o_y_pos        (o_y_pos),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    // turn fraction aligned to the angle width, optionally rounded when narrowed
    function automatic logic [63:0] align_turn(logic [31:0] v, bit rnd);
        int          s;
        logic [63:0] w;
        s = 32 - PB;
        w = 64'(v);
        if (s <= 0) begin
            return w << (-s);
        end
        if (rnd) begin
            w = w + (64'd1 << (s - 1));
        end
        return w >> s;
    endfunction

    // round half up out of Q16 and clamp to the output bound
    function automatic logic signed [OUT_W-1:0] round_clamp(longint q);
        longint v;
        v = (q + 32768) >>> 16;
        if (v > OUT_MAX) begin
            v = OUT_MAX;
        end
        if (v < -OUT_MAX) begin
            v = -OUT_MAX;
        end
        return OUT_W'(v);
    endfunction

    // cordic rotation of the gain-corrected radius to the sample phase
    function automatic point_t predict_point(logic [IDX_W-1:0] idx);
        logic [TURN_W-1:0] ph;
        logic [63:0]       ang;
        logic [1:0]        quad;
        longint            z, x, y, t, dx, dy, xo, yo;
        int                sh;
        point_t            p;
        ph   = cfg_start + idx * cfg_step;
        ang  = align_turn(ph, 1'b0);
        quad = ang[PB-1 -: 2];
        z    = longint'(ang & ((64'd1 << (PB - 2)) - 64'd1));
        x    = longint'((64'(cfg_radius) * 64'(KINV_Q30) + 64'd8192) >> 14);
        y    = 0;
        for (int k = 0; k < NSTG; k++) begin
            sh = k % 32;
            t  = longint'(align_turn(ATAN_TURN32[sh], 1'b1));
            dx = y >>> sh;
            dy = x >>> sh;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - t;
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + t;
            end
        end
        // exact quadrant fold
        case (quad)
            QUAD_FIRST: begin
                xo = x;
                yo = y;
            end
            QUAD_SECOND: begin
                xo = -y;
                yo = x;
            end
            QUAD_THIRD: begin
                xo = -x;
                yo = -y;
            end
            default: begin
                xo = y;
                yo = -x;
            end
        endcase
        p.x    = round_clamp(xo);
        p.y    = round_clamp(yo);
        p.last = (idx == cfg_count);
        return p;
    endfunction

    // one register write, leaves valid high for a following write
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            REG_RADIUS:       cfg_radius = data[RAD_W-1:0];
            REG_PHASE_STEP:   cfg_step   = data;
            REG_START_PHASE:  cfg_start  = data;
            REG_SAMPLE_COUNT: cfg_count  = data[IDX_W-1:0];
            default: ;
        endcase
    endtask

    // wait until every expected point has come out
    task automatic drain();
        @(posedge i_clk);
        while (pending_points.size() != 0) @(posedge i_clk);
    endtask

    // stop the sample stream, drain, then write all registers and one dropped index
    task automatic load_config(logic [31:0] rad, logic [31:0] stp, logic [31:0] st,
                               logic [31:0] cnt);
        i_in_valid <= 1'b0;
        drain();
        write_reg(REG_RADIUS, rad);
        write_reg(($urandom_range(0, 1) != 0) ? REG_PAST_END : REG_ALL_ONES, $urandom());
        write_reg(REG_PHASE_STEP, stp);
        write_reg(REG_START_PHASE, st);
        write_reg(REG_SAMPLE_COUNT, cnt);
        i_cfg_valid <= 1'b0;
    endtask

    // offer one sample word, record its expected point once accepted
    task automatic send_sample(logic [IDX_W-1:0] idx, logic lit, point_t lit_pt);
        point_t e;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_index <= idx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        e = lit ? lit_pt : predict_point(idx);
        pending_points.push_back(e);
    endtask

    // receiver: random stall bursts plus the long hold-off on request
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_reqs != hold_seen) begin
            hold_seen   <= hold_reqs;
            stall_left  <= LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 15);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // point checker
    always @(posedge i_clk) begin
        point_t got;
        point_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.x    = o_x_pos;
            got.y    = o_y_pos;
            got.last = o_last;
            if (pending_points.size() == 0) begin
                bad_words++;
                if (bad_words <= 10) begin
                    $display("unexpected point: x %0d y %0d last %0b", got.x, got.y, got.last);
                end
            end else begin
                want = pending_points.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.last !== want.last) begin
                    bad_words++;
                    if (bad_words <= 10) begin
                        $display("point mismatch: x exp %0d got %0d, y exp %0d got %0d, %s",
                                 want.x, got.x, want.y, got.y,
                                 $sformatf("last exp %0b got %0b", want.last, got.last));
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin
        drow_t            row;
        point_t           lit_pt;
        logic [31:0]      rad, stp, st, cnt;
        logic [IDX_W-1:0] idx, pos;
        bit               sweep;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, registers reloaded whenever a row changes them
        for (int r = 0; r < NDIR; r++) begin
            row = DIRECTED[r];
            if (r > 0 && (row.radius != DIRECTED[r-1].radius || row.step != DIRECTED[r-1].step
                    || row.start != DIRECTED[r-1].start
                    || row.count != DIRECTED[r-1].count)) begin
                load_config(row.radius, row.step, row.start, row.count);
            end
            lit_pt.x    = row.x;
            lit_pt.y    = row.y;
            lit_pt.last = row.last;
            send_sample(row.idx, row.lit, lit_pt);
        end

        // random phases, each under its own register setting
        for (int p = 0; p < NPHASE; p++) begin
            src_idle_en  = (p != NPHASE - 1);
            sink_idle_en = (p != NPHASE - 1);
            sweep        = (p == 1 || p == 3);
            rad = $urandom();
            cnt = $urandom();
            rad[15:0] = (p == 0) ? 16'hFFFF : (p == 3) ? 16'd1 :
                        (p == 4) ? 16'($urandom_range(60000, 65535)) : 16'($urandom());
            cnt[15:0] = sweep ? 16'($urandom_range(8, 40)) : (p == 0) ? 16'hFFFF :
                        (p == NPHASE - 1) ? 16'd0 : 16'($urandom());
            stp = (p == 0) ? 32'hFFFF_FFFF : (p == 4) ? 32'd0 : $urandom();
            st  = (p == 0) ? 32'hFFFF_FFFF : (p == 2) ? 32'd0 : $urandom();
            load_config(rad, stp, st, cnt);
            if (p == 2) begin
                hold_reqs <= hold_reqs + 1;
            end
            pos = '0;
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (sweep) begin
                    // runs from index zero up to the final sample, with some noise
                    if ($urandom_range(0, 9) == 0) begin
                        idx = 16'($urandom());
                    end else begin
                        idx = pos;
                        pos = (pos == cfg_count) ? '0 : pos + 1'b1;
                    end
                end else begin
                    case ($urandom_range(0, 9))
                        0: idx = cfg_count;
                        1: idx = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                        default: idx = 16'($urandom());
                    endcase
                end
                send_sample(idx, 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        drain();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (bad_words == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== circle_point_generator.f =====
design/cpg_pkg.sv
design/cpg_prep.sv
design/cpg_cordic_stage.sv
design/cpg_post.sv
design/circle_point_generator.sv
design/cpg_checker.sv
sim/tb.sv
